// ===== sv/pipcu_pkg.sv =====
// shared constants and types for the point-in-polygon crossing unit
// no dependencies; used by pipcu_fifo, pipcu_back and the top level
package pipcu_pkg;

  // default coordinate width, signed q16.16
  localparam int unsigned COORD_BITS_DEFAULT = 32;

  // depth of the edge queue and of the result queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // fill status of a queue
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== sv/point_in_polygon_crossing_unit.sv =====
// top level of the crossing-number point-in-polygon unit
// depends on pipcu_pkg, pipcu_front, pipcu_fifo and pipcu_back
//
//   channel   direction  handshake          transfer when
//   edges     in         push / full        push && !full
//   result    out        empty / pop        pop && !empty
//
// one edge transfer per cycle while the product stage is not held by a final edge
// a final edge's result reaches the result ports through the edge queue write,
//   the product register and the result queue write
// reset clears the queues, the product stage and the crossing parity
// with the result queue full, a final edge holds in the product stage; edges
//   behind it fill the two-entry edge queue and then full rises
module point_in_polygon_crossing_unit #(
  parameter int unsigned CoordBits = pipcu_pkg::COORD_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // edge channel
  input  logic                        push,
  output logic                        full,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic                        last_edge_i,
  // result channel
  output logic                        empty,
  input  logic                        pop,
  output logic                        inside_res_o
);
  import pipcu_pkg::*;

  // edge word: last flag, straddle flag and four differences
  localparam int unsigned EdgeW = 4 * (CoordBits + 1) + 2;

  logic [EdgeW-1:0] front_edge;
  logic [EdgeW-1:0] queue_edge;
  fifo_stat_t       edge_stat;
  fifo_stat_t       res_stat;
  logic             edge_take;
  logic             res_push;
  logic             res_bit;

  // classify the edge as it arrives
  pipcu_front #(
    .CoordBits (CoordBits)
  ) u_front (
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .last_edge_i (last_edge_i),
    .edge_o      (front_edge)
  );

  // decouples the front from the multiply stage
  pipcu_fifo #(
    .Width (EdgeW),
    .Depth (QUEUE_DEPTH)
  ) u_edge_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_edge),
    .pop_i  (edge_take),
    .data_o (queue_edge),
    .stat_o (edge_stat)
  );

  // cross product sign test and parity
  pipcu_back #(
    .CoordBits (CoordBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_valid_i (!edge_stat.empty),
    .edge_i       (queue_edge),
    .edge_take_o  (edge_take),
    .res_stat_i   (res_stat),
    .res_push_o   (res_push),
    .res_bit_o    (res_bit)
  );

  // result queue in front of the output ports
  pipcu_fifo #(
    .Width (1),
    .Depth (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_bit),
    .pop_i  (pop),
    .data_o (inside_res_o),
    .stat_o (res_stat)
  );

  assign full  = edge_stat.full;
  assign empty = res_stat.empty;

endmodule

// ===== sv/pipcu_fifo.sv =====
// small register queue with push/pop on both sides
// depends on pipcu_pkg for the status struct
module pipcu_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [Width-1:0]     data_i,
  input  logic                 pop_i,
  output logic [Width-1:0]     data_o,
  output pipcu_pkg::fifo_stat_t stat_o
);
  import pipcu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_fire;
  logic             pop_fire;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign push_fire    = push_i && !stat_o.full;
  assign pop_fire     = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && !pop_fire) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && stat_o.empty) |=> $stable(rd_ptr_q))
    else $error("read pointer moved on pop of empty queue");

endmodule

// ===== sv/pipcu_front.sv =====
// front part: forms edge-relative differences and the straddle flag
// no package dependency; feeds the edge queue
module pipcu_front #(
  parameter int unsigned CoordBits = 32
) (
  input  logic signed [CoordBits-1:0]   point_x_i,
  input  logic signed [CoordBits-1:0]   point_y_i,
  input  logic signed [CoordBits-1:0]   start_x_i,
  input  logic signed [CoordBits-1:0]   start_y_i,
  input  logic signed [CoordBits-1:0]   end_x_i,
  input  logic signed [CoordBits-1:0]   end_y_i,
  input  logic                          last_edge_i,
  output logic [4*(CoordBits+1)+1:0]    edge_o
);

  localparam int unsigned W = CoordBits + 1;

  logic [W-1:0] dif_a;  // px - sx
  logic [W-1:0] dif_b;  // py - sy
  logic [W-1:0] dif_c;  // ex - sx
  logic [W-1:0] dif_d;  // ey - sy
  logic         start_ge;
  logic         end_lt;
  logic         straddle;

  assign dif_a = {point_x_i[CoordBits-1], point_x_i} - {start_x_i[CoordBits-1], start_x_i};
  assign dif_b = {point_y_i[CoordBits-1], point_y_i} - {start_y_i[CoordBits-1], start_y_i};
  assign dif_c = {end_x_i[CoordBits-1], end_x_i} - {start_x_i[CoordBits-1], start_x_i};
  assign dif_d = {end_y_i[CoordBits-1], end_y_i} - {start_y_i[CoordBits-1], start_y_i};

  // half-open rule: start at or above the point, end strictly below, or the reverse
  assign start_ge = (start_y_i >= point_y_i);
  assign end_lt   = (end_y_i < point_y_i);
  assign straddle = (start_ge == end_lt);

  assign edge_o = {last_edge_i, straddle, dif_a, dif_b, dif_c, dif_d};

endmodule

// ===== sv/pipcu_back.sv =====
// back part: split cross products, sign test and crossing parity
// depends on pipcu_pkg for the queue status struct
module pipcu_back #(
  parameter int unsigned CoordBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          edge_valid_i,
  input  logic [4*(CoordBits+1)+1:0]    edge_i,
  output logic                          edge_take_o,
  input  pipcu_pkg::fifo_stat_t         res_stat_i,
  output logic                          res_push_o,
  output logic                          res_bit_o
);
  import pipcu_pkg::*;

  localparam int unsigned W  = CoordBits + 1;   // difference width
  localparam int unsigned L  = W / 2;           // low split width
  localparam int unsigned H  = W - L;           // high split width
  localparam int unsigned PH = W + H;           // high partial product width
  localparam int unsigned PL = W + L + 1;       // low partial product width
  localparam int unsigned NW = 2 * W;           // cross product width

  logic               in_last;
  logic               in_strad;
  logic signed [W-1:0] op_a, op_b, op_c, op_d;
  logic signed [H-1:0] d_hi, c_hi;
  logic signed [L:0]   d_lo, c_lo;

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_last_q;
  logic                 s1_strad_q;
  logic                 s1_dneg_q;
  logic signed [PH-1:0] p_adh_q, p_bch_q;
  logic signed [PL-1:0] p_adl_q, p_bcl_q;
  logic                 parity_q, parity_d;

  logic              s1_load;
  logic              retire;
  logic [PH:0]       hi_diff;
  logic [PL:0]       lo_diff;
  logic [NW-1:0]     hi_ext;
  logic [NW-1:0]     lo_ext;
  logic [NW-1:0]     cross_n;
  logic              toggle;

  assign in_last  = edge_i[4*W+1];
  assign in_strad = edge_i[4*W];
  assign op_a     = edge_i[4*W-1:3*W];
  assign op_b     = edge_i[3*W-1:2*W];
  assign op_c     = edge_i[2*W-1:W];
  assign op_d     = edge_i[W-1:0];

  // operand split so each multiplier stays about half the product width
  assign d_hi = op_d[W-1:L];
  assign c_hi = op_c[W-1:L];
  assign d_lo = {1'b0, op_d[L-1:0]};
  assign c_lo = {1'b0, op_c[L-1:0]};

  // a final edge waits while the result queue is full
  assign retire      = s1_valid_q && !(s1_last_q && res_stat_i.full);
  assign s1_load     = !s1_valid_q || retire;
  assign edge_take_o = s1_load && edge_valid_i;
  assign s1_valid_d  = s1_load ? edge_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      parity_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      parity_q   <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_take_o) begin
      s1_last_q  <= in_last;
      s1_strad_q <= in_strad;
      s1_dneg_q  <= op_d[W-1];
      p_adh_q    <= op_a * d_hi;
      p_bch_q    <= op_b * c_hi;
      p_adl_q    <= op_a * d_lo;
      p_bcl_q    <= op_b * c_lo;
    end
  end

  // n = a*d - b*c, recombined from the registered partial products
  assign hi_diff = {p_adh_q[PH-1], p_adh_q} - {p_bch_q[PH-1], p_bch_q};
  assign lo_diff = {p_adl_q[PL-1], p_adl_q} - {p_bcl_q[PL-1], p_bcl_q};
  assign hi_ext  = {{(NW-PH-1){hi_diff[PH]}}, hi_diff};
  assign lo_ext  = {{(NW-PL-1){lo_diff[PL]}}, lo_diff};
  assign cross_n = (hi_ext << L) + lo_ext;

  // point strictly left of the crossing: n nonzero with sign opposite to d
  assign toggle = s1_strad_q && (cross_n != '0) && (cross_n[NW-1] != s1_dneg_q);

  always_comb begin
    parity_d = parity_q;
    if (retire) begin
      parity_d = s1_last_q ? 1'b0 : (parity_q ^ toggle);
    end
  end

  assign res_push_o = retire && s1_last_q;
  assign res_bit_o  = parity_q ^ toggle;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && s1_last_q) |=> !parity_q)
    else $error("parity not cleared after final edge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && !s1_strad_q && !s1_last_q) |=> $stable(parity_q))
    else $error("parity changed on a non-straddling edge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !retire) |=> (s1_valid_q && $stable(p_adh_q) && $stable(s1_last_q)))
    else $error("stalled product stage lost its contents");

endmodule

// ===== test/tb_point_in_polygon_crossing_unit.sv =====
// testbench for point_in_polygon_crossing_unit: drives edge streams, predicts the inside flag
// depends on pipcu_pkg and point_in_polygon_crossing_unit; self-checking, no external files
`timescale 1ns / 1ps

module tb_point_in_polygon_crossing_unit;
  import pipcu_pkg::*;

  localparam int CW = COORD_BITS_DEFAULT;
  localparam time CLK_PERIOD = 4ns;
  localparam int RESET_CYCLES = 12;
  // margin after the last predicted result has been checked
  localparam int DRAIN_CYCLES = 10;
  // longest stretch with no transfer on either side before the run is declared hung
  localparam int STALL_LIMIT = 5000;

  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] ONE = 1 <<< 16;  // 1.0 in q16.16

  // one edge transfer as seen on the input ports
  typedef struct {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic                 last_edge;
  } edge_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  logic signed [CW-1:0] point_x_i;
  logic signed [CW-1:0] point_y_i;
  logic signed [CW-1:0] start_x_i;
  logic signed [CW-1:0] start_y_i;
  logic signed [CW-1:0] end_x_i;
  logic signed [CW-1:0] end_y_i;
  logic last_edge_i;
  logic empty;
  logic pop;
  logic inside_res_o;

  // predictor state: parity of crossings seen in the current region
  logic region_parity;
  // inside flags still owed by the block, oldest first
  logic expected_inside_q[$];

  // idle percentages, changed per phase
  int push_gap_pct;
  int pop_stall_pct;

  int error_count = 0;
  int edges_sent;
  int results_checked = 0;
  int inside_seen = 0;
  int crossings_taken;
  int idle_cycles = 0;

  point_in_polygon_crossing_unit #(
    .CoordBits(CW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .last_edge_i (last_edge_i),
    .empty       (empty),
    .pop         (pop),
    .inside_res_o(inside_res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // true when the edge straddles the point's y line and the point sits strictly left
  // of the crossing; exact cross-product test, wide enough that nothing wraps
  function automatic logic edge_crosses_left(edge_item_t it);
    logic signed [127:0] to_point_x, to_point_y, span_x, span_y, cross_prod;
    logic start_at_or_above, end_below;
    start_at_or_above = (it.start_y >= it.point_y);
    end_below = (it.end_y < it.point_y);
    // half-open rule: exactly one endpoint on each side
    if (start_at_or_above != end_below) return 1'b0;
    to_point_x = it.point_x - it.start_x;
    to_point_y = it.point_y - it.start_y;
    span_x = it.end_x - it.start_x;
    span_y = it.end_y - it.start_y;
    cross_prod = to_point_x * span_y - to_point_y * span_x;
    // point exactly on the crossing never toggles
    if (cross_prod == 0) return 1'b0;
    return cross_prod[127] != span_y[127];
  endfunction

  function automatic edge_item_t make_edge(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                           logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                                           logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                                           logic last);
    edge_item_t it;
    it.point_x = px;
    it.point_y = py;
    it.start_x = sx;
    it.start_y = sy;
    it.end_x = ex;
    it.end_y = ey;
    it.last_edge = last;
    return it;
  endfunction

  function automatic logic signed [CW-1:0] extreme_coord();
    case ($urandom_range(4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [CW-1:0] full_coord();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[CW-1:0];
  endfunction

  // a coordinate for a query point: mostly moderate, sometimes anywhere or at an extreme
  function automatic logic signed [CW-1:0] query_coord();
    int pick;
    pick = $urandom_range(19);
    if (pick < 2) return full_coord();
    if (pick < 3) return extreme_coord();
    return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  // a vertex coordinate near the query: equal to it at times so edges start or end on
  // the point's line
  function automatic logic signed [CW-1:0] vertex_coord(logic signed [CW-1:0] center);
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return full_coord();
    if (pick == 1) return extreme_coord();
    if (pick < 4) return center;
    return center + ($signed($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  // one edge transfer plus the matching update of the predictor
  task automatic send_edge(edge_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < push_gap_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    point_x_i <= it.point_x;
    point_y_i <= it.point_y;
    start_x_i <= it.start_x;
    start_y_i <= it.start_y;
    end_x_i <= it.end_x;
    end_y_i <= it.end_y;
    last_edge_i <= it.last_edge;
    // transfer happens at the first rising edge with full low
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    edges_sent++;
    if (edge_crosses_left(it)) begin
      region_parity = ~region_parity;
      crossings_taken++;
    end
    if (it.last_edge) begin
      expected_inside_q.push_back(region_parity);
      region_parity = 1'b0;
    end
  endtask

  // hand-picked edges: single-edge regions, a square, endpoints on the point's line,
  // the coordinate extremes and points exactly on the crossing
  task automatic test_directed_edges();
    // downward edge, point left, right and on the crossing
    send_edge(make_edge(0, 0, ONE, ONE, ONE, -ONE, 1'b1));
    send_edge(make_edge(2 * ONE, 0, ONE, ONE, ONE, -ONE, 1'b1));
    send_edge(make_edge(ONE, 0, ONE, ONE, ONE, -ONE, 1'b1));
    // horizontal edge lying on the point's line
    send_edge(make_edge(0, 0, ONE, 0, -ONE, 0, 1'b1));
    // unit square around the origin, point inside
    send_edge(make_edge(0, 0, ONE, -ONE, ONE, ONE, 1'b0));
    send_edge(make_edge(0, 0, ONE, ONE, -ONE, ONE, 1'b0));
    send_edge(make_edge(0, 0, -ONE, ONE, -ONE, -ONE, 1'b0));
    send_edge(make_edge(0, 0, -ONE, -ONE, ONE, -ONE, 1'b1));
    // start on the point's line going down, then end on it coming up
    send_edge(make_edge(0, 0, ONE, 0, ONE, -ONE, 1'b0));
    send_edge(make_edge(0, 0, ONE, -ONE, ONE, 0, 1'b1));
    // coordinate extremes
    send_edge(make_edge(COORD_MIN, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1));
    send_edge(make_edge(COORD_MAX, 0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1));
    send_edge(make_edge(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                        1'b1));
    // on the crossing with the widest possible differences
    send_edge(make_edge(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                        1'b1));
    send_edge(make_edge(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                        1'b0));
    send_edge(make_edge(-1, -1, 0, 0, -1, -2, 1'b1));
    // degenerate all-zero edge, then all-ones fields
    send_edge(make_edge(0, 0, 0, 0, 0, 0, 1'b1));
    send_edge(make_edge('1, '1, '1, '1, '1, '1, 1'b1));
  endtask

  // closed polygons of 3 to 8 vertices around one query point; some put the point
  // exactly on an edge's midpoint
  task automatic test_random_polygons(int count);
    logic signed [CW-1:0] vx [8];
    logic signed [CW-1:0] vy [8];
    logic signed [CW-1:0] px, py, half_x, half_y;
    int n;
    for (int r = 0; r < count; r++) begin
      px = query_coord();
      py = query_coord();
      n = $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
        vx[i] = vertex_coord(px);
        vy[i] = vertex_coord(py);
      end
      if ($urandom_range(4) == 0) begin
        // move the point onto the midpoint of the first edge
        half_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        half_y = $signed($urandom_range(1, 1 << 19));
        if ($urandom_range(1)) half_y = -half_y;
        vx[0] = px - half_x;
        vy[0] = py - half_y;
        vx[1] = px + half_x;
        vy[1] = py + half_y;
      end
      for (int i = 0; i < n; i++)
        send_edge(make_edge(px, py, vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n],
                            i == n - 1));
    end
  endtask

  // unrelated edges with random final flags: the point changes from edge to edge,
  // horizontal edges and endpoints on the point's line turn up often
  task automatic test_random_edge_noise(int count);
    edge_item_t it;
    for (int k = 0; k < count; k++) begin
      it.point_x = ($urandom_range(1)) ? full_coord() : query_coord();
      it.point_y = ($urandom_range(1)) ? full_coord() : query_coord();
      it.start_x = vertex_coord(it.point_x);
      it.start_y = vertex_coord(it.point_y);
      it.end_x = vertex_coord(it.point_x);
      it.end_y = ($urandom_range(7) == 0) ? it.start_y : vertex_coord(it.point_y);
      it.last_edge = ($urandom_range(3) == 0);
      send_edge(it);
    end
  endtask

  task automatic run_random_phase(int gap_pct, int stall_pct);
    push_gap_pct = gap_pct;
    pop_stall_pct = stall_pct;
    test_random_polygons(25);
    test_random_edge_noise(70);
  endtask

  // result side: pop drawn fresh on every falling edge, held low in reset
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  // compare each result transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    logic expected_inside;
    if (rst_ni && pop && !empty) begin
      if (expected_inside_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                 $time, inside_res_o);
        error_count++;
      end else begin
        expected_inside = expected_inside_q.pop_front();
        results_checked++;
        if (inside_res_o) inside_seen++;
        if (inside_res_o !== expected_inside) begin
          $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                   $time, expected_inside, inside_res_o);
          error_count++;
        end
      end
    end
  end

  // hang detection: too long without a transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_inside_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    start_x_i = '0;
    start_y_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    last_edge_i = 1'b0;
    region_parity = 1'b0;
    edges_sent = 0;
    crossings_taken = 0;
    push_gap_pct = 33;
    pop_stall_pct = 82;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender sparse, receiver mostly stalled
    test_directed_edges();
    run_random_phase(33, 82);
    // roles swapped
    run_random_phase(82, 33);
    // back to back on both sides
    run_random_phase(0, 0);

    @(negedge clk_i);
    push <= 1'b0;
    while (expected_inside_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d edges in regions and noise, %0d crossings, under three idle mixes",
             edges_sent, crossings_taken);
    $display("checked %0d inside flags, %0d of them inside", results_checked, inside_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
